>>> rtl/core/cau_pkg.sv
// cau_pkg: shared types, codes and helper functions of the complex arithmetic unit
`default_nettype none

package cau_pkg;

   // field and datapath widths
   localparam int FW  = 32;           // operand and result field width
   localparam int RW  = 2 * FW;       // product / magnitude width
   localparam int RMW = RW + 1;       // divider remainder width
   localparam int NW  = RW + FW - 1;  // scaled numerator width, fraction up to 31 bits
   localparam int LW  = FW + 1;       // add / subtract / negate result width
   localparam int CW  = 3;            // opcode width
   localparam int SW  = 2;            // status width

   // queue between front and back
   localparam int QDEPTH = 4;
   localparam int QAW    = $clog2(QDEPTH);
   localparam int QCW    = $clog2(QDEPTH + 1);

   // opcodes
   localparam logic [CW-1:0] CMD_ADD  = 3'd0;
   localparam logic [CW-1:0] CMD_SUB  = 3'd1;
   localparam logic [CW-1:0] CMD_MUL  = 3'd2;
   localparam logic [CW-1:0] CMD_DIV  = 3'd3;
   localparam logic [CW-1:0] CMD_NEG  = 3'd4;
   localparam logic [CW-1:0] CMD_CONJ = 3'd5;

   // status codes
   localparam logic [SW-1:0] ST_OK  = 2'd0;
   localparam logic [SW-1:0] ST_SAT = 2'd1;
   localparam logic [SW-1:0] ST_DZ  = 2'd2;

   // decoded operation, one-hot, all zero for an unused opcode
   typedef struct packed {
      logic add;
      logic sub;
      logic mul;
      logic div;
      logic neg;
      logic conj;
   } op_type;

   // one queued request, operands already sign extended
   typedef struct packed {
      op_type            op;
      logic signed [FW-1:0] a_re;
      logic signed [FW-1:0] a_im;
      logic signed [FW-1:0] b_re;
      logic signed [FW-1:0] b_im;
   } item_type;

   // payload of one divider stage
   typedef struct packed {
      op_type          op;
      logic            dz;
      logic            re_ovf;
      logic            im_ovf;
      logic            re_neg;
      logic            im_neg;
      logic [RW-1:0]   re_mag;
      logic [RW-1:0]   im_mag;
      logic [RW-1:0]   k;
      logic [RMW-1:0]  re_rem;
      logic [RMW-1:0]  im_rem;
      logic [FW-1:0]   re_low;
      logic [FW-1:0]   im_low;
      logic [FW-1:0]   re_q;
      logic [FW-1:0]   im_q;
   } div_type;

   // saturated part plus its flag
   typedef struct packed {
      logic [FW-1:0] val;
      logic          flag;
   } sat_type;

   // one restoring division step on both parts
   function automatic div_type div_step(input div_type s);
      div_type        r;
      logic [RMW-1:0] tr;
      logic [RMW-1:0] ti;
      r  = s;
      tr = {s.re_rem[RMW-2:0], s.re_low[FW-1]};
      ti = {s.im_rem[RMW-2:0], s.im_low[FW-1]};
      if (tr >= RMW'(s.k)) begin
         r.re_rem = tr - RMW'(s.k);
         r.re_q   = {s.re_q[FW-2:0], 1'b1};
      end else begin
         r.re_rem = tr;
         r.re_q   = {s.re_q[FW-2:0], 1'b0};
      end
      if (ti >= RMW'(s.k)) begin
         r.im_rem = ti - RMW'(s.k);
         r.im_q   = {s.im_q[FW-2:0], 1'b1};
      end else begin
         r.im_rem = ti;
         r.im_q   = {s.im_q[FW-2:0], 1'b0};
      end
      r.re_low = s.re_low << 1;
      r.im_low = s.im_low << 1;
      return r;
   endfunction

   // clamp a sign and magnitude to the signed range given by its most negative magnitude
   function automatic sat_type sat_sm(input logic neg, input logic [RW-1:0] mag,
                                      input logic [RW-1:0] minmag);
      sat_type       r;
      logic [RW-1:0] m;
      m      = mag;
      r.flag = 1'b0;
      if (neg) begin
         if (mag > minmag) begin
            m      = minmag;
            r.flag = 1'b1;
         end
         r.val = FW'(~m + RW'(1));
      end else begin
         if (mag > minmag - RW'(1)) begin
            m      = minmag - RW'(1);
            r.flag = 1'b1;
         end
         r.val = FW'(m);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/cau_front.sv
// cau_front: request intake, opcode decode, operand sign extension and request queue
`default_nettype none

module cau_front
   import cau_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [127:0]  req_tdata,   // a_re, a_im, b_re, b_im
   input  wire logic [CW-1:0] req_tuser,   // cmd
   output logic               item_valid,
   input  wire logic          item_pop,
   output item_type           item
);

   localparam int OPW = (DATA_WIDTH > FW) ? FW : ((DATA_WIDTH < 2) ? 2 : DATA_WIDTH);
   localparam int SH  = FW - OPW;

   item_type        entry_ff [QDEPTH];
   logic [QAW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]  cnt_ff, cnt_in;
   item_type        new_item;
   logic            push;
   logic            pop;

   // sign extend a field from its low operand bits
   function automatic logic signed [FW-1:0] sext(input logic [FW-1:0] f);
      logic signed [FW-1:0] t;
      t = $signed(f << SH);
      return t >>> SH;
   endfunction

   // decode and operand preparation
   always_comb begin
      new_item.op = '0;
      case (req_tuser)
         CMD_ADD:  new_item.op.add  = 1'b1;
         CMD_SUB:  new_item.op.sub  = 1'b1;
         CMD_MUL:  new_item.op.mul  = 1'b1;
         CMD_DIV:  new_item.op.div  = 1'b1;
         CMD_NEG:  new_item.op.neg  = 1'b1;
         CMD_CONJ: new_item.op.conj = 1'b1;
         default:  new_item.op      = '0;
      endcase
      new_item.a_re = sext(req_tdata[31:0]);
      new_item.a_im = sext(req_tdata[63:32]);
      new_item.b_re = sext(req_tdata[95:64]);
      new_item.b_im = sext(req_tdata[127:96]);
   end

   // queue control
   assign req_tready = (cnt_ff != QCW'(QDEPTH));
   assign push       = req_tvalid && req_tready;
   assign item_valid = (cnt_ff != '0);
   assign pop        = item_pop && item_valid;
   assign item       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QAW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QAW'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + QCW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - QCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

   // queue fill never passes its depth
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCW'(QDEPTH))
      else $error("request queue overfilled");

   // fill count rises by one on a push without a pop
   a_cnt_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff == $past(cnt_ff) + QCW'(1)))
      else $error("queue count lost a push");

   // requests are held off only by a full queue
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (cnt_ff == QCW'(QDEPTH)))
      else $error("request held off with room in queue");

endmodule

`default_nettype wire

>>> rtl/core/cau_back.sv
// cau_back: product, sum, scaled division and saturation pipeline
`default_nettype none

module cau_back
   import cau_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          item_valid,
   output logic               item_pop,
   input  item_type           item,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [63:0]        rsp_tdata,   // res_re, res_im
   output logic [SW-1:0]      rsp_tuser    // status
);

   localparam int OPW = (DATA_WIDTH > FW) ? FW : ((DATA_WIDTH < 2) ? 2 : DATA_WIDTH);
   localparam int FB  = (FRAC_BITS > FW - 1) ? FW - 1 : ((FRAC_BITS < 0) ? 0 : FRAC_BITS);
   localparam logic [RW-1:0] MINMAG = RW'(1) << (OPW - 1);

   logic en;

   // stage 1: products and linear results
   logic                 v1_ff;
   op_type               op1_ff;
   logic                 dz1_ff;
   logic signed [RW-1:0] p_ar_br_ff, p_ai_bi_ff, p_ar_bi_ff, p_ai_br_ff;
   logic signed [RW-1:0] p_br_br_ff, p_bi_bi_ff;
   logic signed [LW-1:0] re_lin_ff, re_lin_in;
   logic signed [LW-1:0] im_lin_ff, im_lin_in;

   // stage 2: signed sums split into sign and magnitude
   logic                 v2_ff;
   op_type               op2_ff;
   logic                 dz2_ff;
   logic                 re_neg_ff, im_neg_ff;
   logic [RW-1:0]        re_mag_ff, im_mag_ff;
   logic [RW-1:0]        k_ff;
   logic signed [RMW-1:0] re_val, im_val, re_abs, im_abs;

   // stage 3 and divider
   logic [NW-1:0]        n_re, n_im;
   div_type              st_in;
   div_type              st_ff [FW+1];
   logic                 dv_ff [FW+1];

   // output register
   div_type              fin;
   logic [RW-1:0]        fre_mag, fim_mag;
   sat_type              sre, sim;

   assign en       = !rsp_tvalid || rsp_tready;
   assign item_pop = en && item_valid;

   // linear operations
   always_comb begin
      re_lin_in = '0;
      im_lin_in = '0;
      if (item.op.add) begin
         re_lin_in = LW'(item.a_re) + LW'(item.b_re);
         im_lin_in = LW'(item.a_im) + LW'(item.b_im);
      end else if (item.op.sub) begin
         re_lin_in = LW'(item.a_re) - LW'(item.b_re);
         im_lin_in = LW'(item.a_im) - LW'(item.b_im);
      end else if (item.op.neg) begin
         re_lin_in = -LW'(item.a_re);
         im_lin_in = -LW'(item.a_im);
      end else if (item.op.conj) begin
         re_lin_in = LW'(item.a_re);
         im_lin_in = -LW'(item.a_im);
      end
   end

   // stage 1 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= item_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op1_ff     <= item.op;
         dz1_ff     <= (item.b_re == '0) && (item.b_im == '0);
         p_ar_br_ff <= item.a_re * item.b_re;
         p_ai_bi_ff <= item.a_im * item.b_im;
         p_ar_bi_ff <= item.a_re * item.b_im;
         p_ai_br_ff <= item.a_im * item.b_re;
         p_br_br_ff <= item.b_re * item.b_re;
         p_bi_bi_ff <= item.b_im * item.b_im;
         re_lin_ff  <= re_lin_in;
         im_lin_ff  <= im_lin_in;
      end
   end

   // product sums per operation
   always_comb begin
      if (op1_ff.mul) begin
         re_val = RMW'(p_ar_br_ff) - RMW'(p_ai_bi_ff);
         im_val = RMW'(p_ar_bi_ff) + RMW'(p_ai_br_ff);
      end else if (op1_ff.div) begin
         re_val = RMW'(p_ar_br_ff) + RMW'(p_ai_bi_ff);
         im_val = RMW'(p_ai_br_ff) - RMW'(p_ar_bi_ff);
      end else begin
         re_val = RMW'(re_lin_ff);
         im_val = RMW'(im_lin_ff);
      end
      re_abs = re_val[RMW-1] ? -re_val : re_val;
      im_abs = im_val[RMW-1] ? -im_val : im_val;
   end

   // stage 2 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op2_ff    <= op1_ff;
         dz2_ff    <= dz1_ff;
         re_neg_ff <= re_val[RMW-1];
         im_neg_ff <= im_val[RMW-1];
         re_mag_ff <= re_abs[RW-1:0];
         im_mag_ff <= im_abs[RW-1:0];
         k_ff      <= RW'($unsigned(p_br_br_ff)) + RW'($unsigned(p_bi_bi_ff));
      end
   end

   // scaling and divider setup
   always_comb begin
      n_re          = NW'(re_mag_ff) << FB;
      n_im          = NW'(im_mag_ff) << FB;
      st_in.op      = op2_ff;
      st_in.dz      = dz2_ff;
      st_in.re_neg  = re_neg_ff;
      st_in.im_neg  = im_neg_ff;
      st_in.k       = k_ff;
      st_in.re_ovf  = (n_re >> FW) >= NW'(k_ff);
      st_in.im_ovf  = (n_im >> FW) >= NW'(k_ff);
      st_in.re_rem  = RMW'(n_re >> FW);
      st_in.im_rem  = RMW'(n_im >> FW);
      st_in.re_low  = n_re[FW-1:0];
      st_in.im_low  = n_im[FW-1:0];
      st_in.re_q    = '0;
      st_in.im_q    = '0;
      st_in.re_mag  = op2_ff.mul ? (re_mag_ff >> FB) : re_mag_ff;
      st_in.im_mag  = op2_ff.mul ? (im_mag_ff >> FB) : im_mag_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (en) begin
         dv_ff[0] <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0] <= st_in;
      end
   end

   // divider stages, one quotient bit each
   for (genvar i = 0; i < FW; i++) begin : g_div
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[i+1] <= 1'b0;
         end else if (en) begin
            dv_ff[i+1] <= dv_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[i+1] <= div_step(st_ff[i]);
         end
      end
   end

   // final magnitude selection and saturation
   always_comb begin
      fin     = st_ff[FW];
      fre_mag = fin.re_mag;
      fim_mag = fin.im_mag;
      if (fin.op.div) begin
         fre_mag = fin.re_ovf ? (RW'(1) << FW) : RW'(fin.re_q);
         fim_mag = fin.im_ovf ? (RW'(1) << FW) : RW'(fin.im_q);
      end
      sre = sat_sm(fin.re_neg, fre_mag, MINMAG);
      sim = sat_sm(fin.im_neg, fim_mag, MINMAG);
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid <= 1'b0;
      end else if (en) begin
         rsp_tvalid <= dv_ff[FW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (fin.op.div && fin.dz) begin
            rsp_tdata <= '0;
            rsp_tuser <= ST_DZ;
         end else begin
            rsp_tdata <= {sim.val, sre.val};
            rsp_tuser <= (sre.flag || sim.flag) ? ST_SAT : ST_OK;
         end
      end
   end

   // division by zero gives a zero result
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ST_DZ) |-> (rsp_tdata == '0))
      else $error("division by zero with nonzero result");

   // only defined status codes leave the block
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == ST_OK || rsp_tuser == ST_SAT || rsp_tuser == ST_DZ))
      else $error("undefined status code");

   // a held result keeps the pipeline frozen
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(dv_ff[FW]) && $stable(v1_ff))
      else $error("pipeline moved under a stalled result");

endmodule

`default_nettype wire

>>> rtl/core/complex_arithmetic_unit.sv
// complex_arithmetic_unit: top level of the fixed-point complex arithmetic unit
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  tdata a_re,a_im,b_re,b_im; tuser cmd
//   rsp      out        rsp_tvalid/rsp_tready  tdata res_re,res_im; tuser status
//
// one request per cycle unless results stall; products, sums, divider, result register
// latency is set by the 32-stage restoring divider, which every request passes through
// reset clears the 4-entry request queue and all pipeline valid bits
// a result not taken freezes the back pipeline; the queue keeps taking requests until full
`default_nettype none

module complex_arithmetic_unit
   import cau_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [127:0]  req_tdata,   // a_re, a_im, b_re, b_im
   input  wire logic [CW-1:0] req_tuser,   // cmd
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [63:0]        rsp_tdata,   // res_re, res_im
   output logic [SW-1:0]      rsp_tuser    // status
);

   logic     item_valid;
   logic     item_pop;
   item_type item;

   // intake and request queue
   cau_front #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .item       (item)
   );

   // arithmetic pipeline
   cau_back #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .item       (item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// tb_top: self-checking stream testbench of the fixed-point complex arithmetic unit
`default_nettype none

module tb_top;
   import cau_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RAND_ITEMS  = 1550;
   localparam int PAUSE_AT    = 900;
   localparam int DRAIN_WAIT  = 120;
   localparam int CYCLE_LIMIT = 400000;
   localparam longint unsigned MINMAG = 64'h8000_0000;
   localparam longint unsigned MAXMAG = 64'h7FFF_FFFF;
   localparam int FB = 16;

   typedef struct {
      logic [CW-1:0] cmd;
      logic [31:0]   a_re, a_im, b_re, b_im;
   } request_type;

   typedef struct {
      logic [31:0]   re, im;
      logic [SW-1:0] st;
   } answer_type;

   typedef struct {
      logic            neg;
      longint unsigned m;
   } smag_type;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;   // a_re, a_im, b_re, b_im
   logic [CW-1:0] req_tuser = '0;  // cmd
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [63:0]  rsp_tdata;        // res_re, res_im
   logic [SW-1:0] rsp_tuser;       // status

   request_type pending_reqs[$];
   answer_type  expected_answers[$];
   int          mismatches = 0;
   int          cycles = 0;
   int          sent = 0;
   bit          stim_done = 0;

   complex_arithmetic_unit uut (.*);

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // sign and magnitude helpers
   function automatic longint unsigned mag_of(longint x);
      return x < 0 ? 64'd0 - 64'(x) : 64'(x);
   endfunction

   function automatic smag_type mul_sm(longint x, longint y);
      smag_type r;
      r.m = mag_of(x) * mag_of(y);
      r.neg = ((x < 0) != (y < 0)) && r.m != 0;
      return r;
   endfunction

   function automatic smag_type flip_sm(smag_type x);
      x.neg = !x.neg && x.m != 0;
      return x;
   endfunction

   function automatic smag_type add_sm(smag_type x, smag_type y);
      smag_type r;
      if (x.neg == y.neg) begin
         r.m = x.m + y.m;
         r.neg = x.neg;
      end else if (x.m >= y.m) begin
         r.m = x.m - y.m;
         r.neg = x.neg;
      end else begin
         r.m = y.m - x.m;
         r.neg = y.neg;
      end
      if (r.m == 0) r.neg = 0;
      return r;
   endfunction

   function automatic logic [31:0] clamp_sm(smag_type x, inout bit flag);
      if (x.neg) begin
         if (x.m > MINMAG) begin
            flag = 1;
            return 32'h8000_0000;
         end
         return 32'(64'd0 - x.m);
      end
      if (x.m > MAXMAG) begin
         flag = 1;
         return 32'h7FFF_FFFF;
      end
      return 32'(x.m);
   endfunction

   function automatic logic [31:0] clamp_int(longint x, inout bit flag);
      smag_type s;
      s.neg = x < 0;
      s.m = mag_of(x);
      return clamp_sm(s, flag);
   endfunction

   // floor(m * 2^FB / k), stopping once far out of range
   function automatic longint unsigned frac_quot(longint unsigned m, longint unsigned k);
      longint unsigned q, r;
      q = m / k;
      r = m % k;
      for (int i = 0; i < FB; i++) begin
         if (q > (64'd1 << 40)) break;
         q = q << 1;
         r = r << 1;
         if (r >= k) begin
            r = r - k;
            q = q | 64'd1;
         end
      end
      return q;
   endfunction

   function automatic answer_type complex_result(request_type q);
      answer_type a;
      longint ar, ai, br, bi;
      longint unsigned k;
      smag_type pr, pi;
      bit sat;
      ar = longint'($signed(q.a_re));
      ai = longint'($signed(q.a_im));
      br = longint'($signed(q.b_re));
      bi = longint'($signed(q.b_im));
      sat = 0;
      a.re = '0;
      a.im = '0;
      a.st = ST_OK;
      case (q.cmd)
         CMD_ADD: begin
            a.re = clamp_int(ar + br, sat);
            a.im = clamp_int(ai + bi, sat);
         end
         CMD_SUB: begin
            a.re = clamp_int(ar - br, sat);
            a.im = clamp_int(ai - bi, sat);
         end
         CMD_MUL: begin
            pr = add_sm(mul_sm(ar, br), flip_sm(mul_sm(ai, bi)));
            pi = add_sm(mul_sm(ar, bi), mul_sm(ai, br));
            pr.m = pr.m >> FB;
            pi.m = pi.m >> FB;
            a.re = clamp_sm(pr, sat);
            a.im = clamp_sm(pi, sat);
         end
         CMD_DIV: begin
            if (br == 0 && bi == 0) begin
               a.st = ST_DZ;
            end else begin
               k = mag_of(br) * mag_of(br) + mag_of(bi) * mag_of(bi);
               pr = add_sm(mul_sm(ar, br), mul_sm(ai, bi));
               pi = add_sm(mul_sm(ai, br), flip_sm(mul_sm(ar, bi)));
               pr.m = frac_quot(pr.m, k);
               pi.m = frac_quot(pi.m, k);
               a.re = clamp_sm(pr, sat);
               a.im = clamp_sm(pi, sat);
            end
         end
         CMD_NEG: begin
            a.re = clamp_int(-ar, sat);
            a.im = clamp_int(-ai, sat);
         end
         CMD_CONJ: begin
            a.re = q.a_re;
            a.im = clamp_int(-ai, sat);
         end
         default: ;
      endcase
      if (a.st == ST_OK && sat) a.st = ST_SAT;
      return a;
   endfunction

   // operand value: extremes, zero, small, medium or full range
   function automatic logic [31:0] pick_operand();
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'(0);
         3, 4, 5: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
         6, 7: return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
         default: return $urandom;
      endcase
   endfunction

   function automatic request_type make_req(logic [CW-1:0] c, logic [31:0] ar,
                                            logic [31:0] ai, logic [31:0] br,
                                            logic [31:0] bi);
      request_type q;
      q.cmd = c;
      q.a_re = ar;
      q.a_im = ai;
      q.b_re = br;
      q.b_im = bi;
      return q;
   endfunction

   // stimulus: directed corners, then random requests
   initial begin
      request_type q;
      logic [31:0] mn, mx;
      mn = 32'h8000_0000;
      mx = 32'h7FFF_FFFF;
      pending_reqs.push_back(make_req(CMD_ADD, mx, mn, mx, mn));
      pending_reqs.push_back(make_req(CMD_ADD, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_8000, 32'd5));
      pending_reqs.push_back(make_req(CMD_SUB, mn, mx, mx, mn));
      pending_reqs.push_back(make_req(CMD_SUB, 32'd7, 32'd9, 32'd3, 32'hFFFF_FFFF));
      pending_reqs.push_back(make_req(CMD_MUL, mx, mx, mx, mx));
      pending_reqs.push_back(make_req(CMD_MUL, mn, mn, mn, mn));
      pending_reqs.push_back(make_req(CMD_MUL, 32'h0001_8000, 32'hFFFE_0000, 32'h0000_4000, 32'd3));
      pending_reqs.push_back(make_req(CMD_MUL, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'd1));
      pending_reqs.push_back(make_req(CMD_DIV, 32'h0003_0000, 32'h0001_0000, 32'd0, 32'd0));
      pending_reqs.push_back(make_req(CMD_DIV, mx, mn, 32'd0, 32'd0));
      pending_reqs.push_back(make_req(CMD_DIV, mx, mx, 32'd1, 32'd0));
      pending_reqs.push_back(make_req(CMD_DIV, mn, mn, mn, mn));
      pending_reqs.push_back(make_req(CMD_DIV, 32'h0003_0000, 32'hFFFE_0000, 32'h0001_0000,
                                      32'h0002_0000));
      pending_reqs.push_back(make_req(CMD_DIV, 32'd1, 32'd0, mx, mx));
      pending_reqs.push_back(make_req(CMD_NEG, mn, mn, mx, mx));
      pending_reqs.push_back(make_req(CMD_NEG, mx, 32'd0, 32'd0, 32'd0));
      pending_reqs.push_back(make_req(CMD_CONJ, mn, mn, 32'd5, 32'd5));
      pending_reqs.push_back(make_req(CMD_CONJ, mx, mx, mn, mn));
      pending_reqs.push_back(make_req(3'd6, mx, mx, mx, mx));
      pending_reqs.push_back(make_req(3'd7, mn, mn, mn, mn));
      pending_reqs.push_back(make_req(3'd7, $urandom, $urandom, $urandom, $urandom));
      for (int i = 0; i < RAND_ITEMS; i++) begin
         q = make_req(CW'($urandom_range(0, 7)), pick_operand(), pick_operand(),
                      pick_operand(), pick_operand());
         if ($urandom_range(0, 9) < 8) q.cmd = CW'($urandom_range(0, 5));
         pending_reqs.push_back(q);
      end
      repeat (3) @(posedge clock);
      reset <= 0;
   end

   // request driver
   always @(posedge clock) begin
      request_type q;
      bit idle;
      if (reset) begin
         req_tvalid <= 0;
      end else if (!req_tvalid || req_tready) begin
         idle = (cycles < 1500 || cycles > 3000) && ($urandom_range(0, 99) < 26);
         if (sent == PAUSE_AT && expected_answers.size() != 0) idle = 1;
         if (pending_reqs.size() == 0) begin
            req_tvalid <= 0;
            stim_done <= 1;
         end else if (idle) begin
            req_tvalid <= 0;
         end else begin
            q = pending_reqs.pop_front();
            req_tvalid <= 1;
            req_tdata <= {q.b_im, q.b_re, q.a_im, q.a_re};
            req_tuser <= q.cmd;
            sent <= sent + 1;
         end
      end
   end

   // response ready
   always @(posedge clock) begin
      if (reset) rsp_tready <= 0;
      else rsp_tready <= (cycles > 4000 && cycles < 5500) || ($urandom_range(0, 99) >= 26);
   end

   // monitor: predict on accepted requests, check accepted responses
   always @(posedge clock) begin
      request_type q;
      answer_type e;
      cycles <= cycles + 1;
      if (!reset && req_tvalid && req_tready) begin
         q.cmd = req_tuser;
         {q.b_im, q.b_re, q.a_im, q.a_re} = req_tdata;
         expected_answers.push_back(complex_result(q));
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_answers.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
               $display("unexpected response %h status %0d", rsp_tdata, rsp_tuser);
         end else begin
            e = expected_answers.pop_front();
            if (rsp_tdata[31:0] !== e.re || rsp_tdata[63:32] !== e.im || rsp_tuser !== e.st) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("mismatch: expected re %h im %h st %0d, got re %h im %h st %0d",
                           e.re, e.im, e.st, rsp_tdata[31:0], rsp_tdata[63:32], rsp_tuser);
            end
         end
      end
   end

   // end of run
   initial begin
      wait (stim_done);
      while (expected_answers.size() != 0 && cycles < CYCLE_LIMIT) @(posedge clock);
      if (cycles >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
      end else begin
         repeat (DRAIN_WAIT) @(posedge clock);
         if (mismatches == 0 && expected_answers.size() == 0) $display("TB_OK");
         else $display("TB_ERROR");
      end
      $finish;
   end

   // watchdog
   always @(posedge clock) begin
      if (cycles >= CYCLE_LIMIT + DRAIN_WAIT + 10) begin
         $display("TB_ERROR");
         $finish;
      end
   end
endmodule

`default_nettype wire

>>> files.f
rtl/core/cau_pkg.sv
rtl/core/cau_front.sv
rtl/core/cau_back.sv
rtl/core/complex_arithmetic_unit.sv
sim/tb_top.sv
